FILE: src/imconv_pkg.sv
// Shared constants, types and register indexes for the 2D convolution block.
package imconv_pkg;

  localparam int KERNEL_RADIUS    = 1;
  localparam int MAX_PADDED_WIDTH = 1028;

  localparam int K_SIZE  = 2 * KERNEL_RADIUS + 1;
  localparam int N_LINES = 2 * KERNEL_RADIUS;
  localparam int K_TAPS  = K_SIZE * K_SIZE;

  localparam int PIX_W   = 16;
  localparam int DIM_W   = 11;
  localparam int WORD_W  = PIX_W * N_LINES;
  localparam int ADDR_W  = $clog2(MAX_PADDED_WIDTH);

  localparam int COEF_W        = 12;
  localparam int COEF_FRAC     = 10;
  localparam int COEF_PER_WORD = 5;
  localparam int CWORD_W       = COEF_W * COEF_PER_WORD;
  localparam int CWORDS_USED   = (K_TAPS + COEF_PER_WORD - 1) / COEF_PER_WORD;
  localparam int CWORD_SEL_W   = (CWORDS_USED > 1) ? $clog2(CWORDS_USED) : 1;

  localparam int PROD_W  = PIX_W + 1 + COEF_W;
  localparam int ACC_W   = PROD_W + $clog2(K_TAPS);
  localparam int VALUE_W = 32;
  localparam int SCALED_W = ACC_W - COEF_FRAC;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 8);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CWORD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_LAST    = 3'd6;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1028;

  typedef struct packed {
    logic produce;
    logic row_end;
    logic frame_end;
  } tag_t;

endpackage

FILE: src/imconv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module imconv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1028,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/image_convolution_2d.sv
// Top level of the streaming 2D image convolution with line stores.
//
// Usage: feed an edge-padded frame in raster order on in_pixel, one pixel per
// transfer; in_frame_start marks the first pixel of a frame and clears the row
// and column counts. Configure padded_width, padded_height and the two packed
// coefficient words through the cfg_ channel (index, data) while idle; cfg_ready
// is always high. One result leaves on out_value for each pixel that completes
// a full window, with out_row_end on the last result of an image row and
// out_frame_end on the last result of the frame.
// A result passes through the line store read, window update, multiply, row
// sums and final sum into the output queue before it is offered.
// Throughput: one pixel per cycle while in_ready is high, set by the single
// read-modify-write line store access per pixel; an access to the entry
// written the cycle before is forwarded. in_ready drops only when the
// eight-entry output queue plus the results in flight would overflow, so a
// stalled receiver backs up the input after eight results. Reset clears the
// counters, window and queue and loads the default sizes and zero coefficients;
// the line store holds no reset value, and no result uses an entry not yet written in its frame.
module image_convolution_2d (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [imconv_pkg::PIX_W-1:0]          in_pixel,
  input  logic                                  in_frame_start,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [imconv_pkg::VALUE_W-1:0] out_value,
  output logic                                  out_row_end,
  output logic                                  out_frame_end,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [imconv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [imconv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int K     = imconv_pkg::K_SIZE;
  localparam int NL    = imconv_pkg::N_LINES;
  localparam int PW    = imconv_pkg::PIX_W;
  localparam int DW    = imconv_pkg::DIM_W;
  localparam int AW    = imconv_pkg::ADDR_W;
  localparam int WW    = imconv_pkg::WORD_W;
  localparam int CW    = imconv_pkg::COEF_W;
  localparam int CPW   = imconv_pkg::COEF_PER_WORD;
  localparam int PRW   = imconv_pkg::PROD_W;
  localparam int ACW   = imconv_pkg::ACC_W;
  localparam int SCW   = imconv_pkg::SCALED_W;
  localparam int VW    = imconv_pkg::VALUE_W;
  localparam int FD    = imconv_pkg::FIFO_DEPTH;
  localparam int FPW   = imconv_pkg::FIFO_PTR_W;
  localparam int FCW   = imconv_pkg::FIFO_CNT_W;
  localparam int OW    = imconv_pkg::OCC_W;
  localparam int NCW   = imconv_pkg::CWORDS_USED;
  localparam int CSW   = imconv_pkg::CWORD_SEL_W;
  localparam int MAXW  = imconv_pkg::MAX_PADDED_WIDTH;
  localparam logic signed [ACW-1:0] ROUND_HALF = ACW'(1) << (imconv_pkg::COEF_FRAC - 1);

  // configuration
  logic [DW-1:0]                     width_r;
  logic [DW-1:0]                     height_r;
  logic [imconv_pkg::CWORD_W-1:0]    coeff_r [NCW];
  logic [imconv_pkg::CFG_IDX_W-1:0]  coeff_sel;

  assign cfg_ready = 1'b1;
  assign coeff_sel = cfg_index - imconv_pkg::CFG_COEFF_FIRST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= imconv_pkg::DIM_RESET;
      height_r <= imconv_pkg::DIM_RESET;
      for (int i = 0; i < NCW; i++) begin
        coeff_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        imconv_pkg::CFG_PADDED_WIDTH: begin
          width_r <= cfg_data[DW-1:0];
        end
        imconv_pkg::CFG_PADDED_HEIGHT: begin
          height_r <= cfg_data[DW-1:0];
        end
        default: begin
          if (cfg_index inside {[imconv_pkg::CFG_COEFF_FIRST:imconv_pkg::CFG_COEFF_LAST]} &&
              32'(coeff_sel) < NCW) begin
            coeff_r[coeff_sel[CSW-1:0]] <= cfg_data;
          end
        end
      endcase
    end
  end

  // counters and pixel intake
  logic [DW-1:0]   col_r, row_r;
  logic [DW-1:0]   col_cur, row_cur;
  logic [DW-1:0]   w_eff;
  logic [AW-1:0]   rd_addr;
  logic            last_col, last_row, produce;
  logic            in_acc;
  imconv_pkg::tag_t in_tag;

  assign in_acc  = in_valid && in_ready;
  assign col_cur = in_frame_start ? '0 : col_r;
  assign row_cur = in_frame_start ? '0 : row_r;
  assign w_eff   = (32'(width_r) > MAXW) ? DW'(MAXW) : width_r;
  assign rd_addr = (32'(col_cur) >= MAXW) ? '0 : AW'(col_cur);
  assign last_col = ({1'b0, col_cur} + (DW+1)'(1)) >= {1'b0, w_eff};
  assign last_row = ({1'b0, row_cur} + (DW+1)'(1)) >= {1'b0, height_r};
  assign produce  = (32'(row_cur) >= NL) && (32'(col_cur) >= NL);
  assign in_tag   = '{produce: produce, row_end: last_col,
                      frame_end: last_col && last_row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_cur + DW'(1);
      end else begin
        col_r <= col_cur + DW'(1);
        row_r <= row_cur;
      end
    end
  end

  // stage 1: line store read-modify-write
  logic             s1_valid_r;
  imconv_pkg::tag_t s1_tag_r;
  logic [PW-1:0]    s1_px_r;
  logic [AW-1:0]    s1_addr_r;
  logic             fwd_hit_r;
  logic [WW-1:0]    fwd_data_r;
  logic [WW-1:0]    ram_rdata, rd_word, wr_word;
  logic             fwd_hit_nxt;

  assign fwd_hit_nxt = in_acc && s1_valid_r && (s1_addr_r == rd_addr);
  assign rd_word     = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign wr_word     = {s1_px_r, rd_word[WW-1:PW]};

  imconv_ram #(
    .WIDTH(WW),
    .DEPTH(MAXW)
  ) u_line_store (
    .clk  (clk),
    .we   (s1_valid_r),
    .waddr(s1_addr_r),
    .wdata(wr_word),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      fwd_hit_r  <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tag_r  <= in_tag;
      s1_px_r   <= in_pixel;
      s1_addr_r <= rd_addr;
    end
    fwd_data_r <= wr_word;
  end

  // window shift
  logic [PW-1:0]    col_pix [K];
  logic [PW-1:0]    win_r [K][K];
  logic             s2_valid_r;
  imconv_pkg::tag_t s2_tag_r;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      col_pix[i] = rd_word[i*PW +: PW];
    end
    col_pix[NL] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < K; i++) begin
        for (int k = 0; k < K; k++) begin
          win_r[i][k] <= '0;
        end
      end
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_valid_r) begin
        for (int i = 0; i < K; i++) begin
          for (int k = 0; k + 1 < K; k++) begin
            win_r[i][k] <= win_r[i][k+1];
          end
          win_r[i][K-1] <= col_pix[i];
        end
      end
      s2_valid_r <= s1_valid_r && s1_tag_r.produce;
    end
  end

  always_ff @(posedge clk) begin
    s2_tag_r <= s1_tag_r;
  end

  // stage 3: products with the flipped kernel
  logic signed [PRW-1:0] prod_r [K][K];
  logic                  s3_valid_r;
  imconv_pkg::tag_t      s3_tag_r;

  for (genvar gi = 0; gi < K; gi++) begin : g_row
    for (genvar gk = 0; gk < K; gk++) begin : g_tap
      localparam int N = (K - 1 - gi) * K + (K - 1 - gk);
      logic signed [CW-1:0] coef;
      assign coef = signed'(coeff_r[N / CPW][CW * (N % CPW) +: CW]);
      always_ff @(posedge clk) begin
        prod_r[gi][gk] <= PRW'(signed'({1'b0, win_r[gi][gk]}) * coef);
      end
    end
  end

  // stage 4: row sums, rounding offset folded into the first row
  logic signed [ACW-1:0] rowsum_r [K];
  logic signed [ACW-1:0] rowsum_nxt [K];
  logic                  s4_valid_r;
  imconv_pkg::tag_t      s4_tag_r;

  always_comb begin
    for (int i = 0; i < K; i++) begin
      rowsum_nxt[i] = (i == 0) ? ROUND_HALF : '0;
      for (int k = 0; k < K; k++) begin
        rowsum_nxt[i] = rowsum_nxt[i] + ACW'(prod_r[i][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < K; i++) begin
      rowsum_r[i] <= rowsum_nxt[i];
    end
    s3_tag_r <= s2_tag_r;
    s4_tag_r <= s3_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // final sum and scaling
  logic signed [ACW-1:0] total;
  logic signed [VW-1:0]  scaled;

  always_comb begin
    total = '0;
    for (int i = 0; i < K; i++) begin
      total = total + rowsum_r[i];
    end
  end

  assign scaled = {{(VW - SCW){total[ACW-1]}}, total[ACW-1:imconv_pkg::COEF_FRAC]};

  // output queue
  logic signed [VW-1:0] fifo_value_r [FD];
  logic                 fifo_row_end_r [FD];
  logic                 fifo_frame_end_r [FD];
  logic [FPW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0]       cnt_r;
  logic                 push, pop;
  logic [OW-1:0]        occupancy;

  assign push = s4_valid_r;
  assign pop  = out_valid && out_ready;

  assign occupancy = OW'(cnt_r) + OW'(s1_valid_r && s1_tag_r.produce) + OW'(s2_valid_r)
                   + OW'(s3_valid_r) + OW'(s4_valid_r);
  assign in_ready  = occupancy < OW'(FD);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_value_r[wr_ptr_r]     <= scaled;
      fifo_row_end_r[wr_ptr_r]   <= s4_tag_r.row_end;
      fifo_frame_end_r[wr_ptr_r] <= s4_tag_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == FD - 1) ? '0 : wr_ptr_r + FPW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == FD - 1) ? '0 : rd_ptr_r + FPW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + FCW'(1);
        2'b01:   cnt_r <= cnt_r - FCW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign out_valid     = cnt_r != '0;
  assign out_value     = fifo_value_r[rd_ptr_r];
  assign out_row_end   = fifo_row_end_r[rd_ptr_r];
  assign out_frame_end = fifo_frame_end_r[rd_ptr_r];

endmodule

FILE: src/imconv_checker.sv
// Port-level checks for the 2D convolution block and their binding.
module imconv_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [imconv_pkg::VALUE_W-1:0] out_value,
  input logic                                  out_row_end,
  input logic                                  out_frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_row_end) &&
                                $stable(out_frame_end))
    else $error("stalled result changed");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind image_convolution_2d imconv_checker u_imconv_checker (.*);

FILE: test/tb_top.sv
// Self-checking testbench for the streaming 3x3 image convolution block.
`timescale 1ns / 1ps

module tb_top;

  localparam int PIX_W            = imconv_pkg::PIX_W;
  localparam int DIM_W            = imconv_pkg::DIM_W;
  localparam int VALUE_W          = imconv_pkg::VALUE_W;
  localparam int CFG_IDX_W        = imconv_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W       = imconv_pkg::CFG_DATA_W;
  localparam int N_LINES          = imconv_pkg::N_LINES;
  localparam int K_SIZE           = imconv_pkg::K_SIZE;
  localparam int MAX_PADDED_WIDTH = imconv_pkg::MAX_PADDED_WIDTH;
  localparam int COEF_W           = imconv_pkg::COEF_W;
  localparam int COEF_PER_WORD    = imconv_pkg::COEF_PER_WORD;
  localparam int COEF_FRAC        = imconv_pkg::COEF_FRAC;
  localparam logic [DIM_W-1:0] DIM_RESET = imconv_pkg::DIM_RESET;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH  = imconv_pkg::CFG_PADDED_WIDTH;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_HEIGHT = imconv_pkg::CFG_PADDED_HEIGHT;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_FIRST   = imconv_pkg::CFG_COEFF_FIRST;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_LAST    = imconv_pkg::CFG_COEFF_LAST;

  localparam int N_COEF_REGS = int'(CFG_COEFF_LAST) - int'(CFG_COEFF_FIRST) + 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int RANDOM_ITEMS = 1900;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      row_end;
    logic                      frame_end;
  } conv_out_t;

  class conv_tracker;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [CFG_DATA_W-1:0] coef_words [N_COEF_REGS];
    logic [PIX_W-1:0]      line_rows [N_LINES][MAX_PADDED_WIDTH];
    logic [PIX_W-1:0]      win [K_SIZE][K_SIZE];
    logic [DIM_W-1:0]      col_cnt;
    logic [DIM_W-1:0]      row_cnt;
    conv_out_t             expected_values [$];
    int                    mismatches;

    function new();
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      foreach (coef_words[i]) coef_words[i] = '0;
      foreach (line_rows[i, j]) line_rows[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col_cnt = '0;
      row_cnt = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PADDED_WIDTH) begin
        width_reg = data[DIM_W-1:0];
      end else if (idx == CFG_PADDED_HEIGHT) begin
        height_reg = data[DIM_W-1:0];
      end else if (idx >= CFG_COEFF_FIRST && idx <= CFG_COEFF_LAST) begin
        coef_words[idx - CFG_COEFF_FIRST] = data;
      end
    endfunction

    function longint tap(int n);
      logic signed [COEF_W-1:0] c;
      c = coef_words[n / COEF_PER_WORD][COEF_W * (n % COEF_PER_WORD) +: COEF_W];
      return longint'(c);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic fs);
      int unsigned w, colx, rowx;
      int i, k;
      logic [PIX_W-1:0] fresh [K_SIZE];
      bit last_col, last_row;
      longint acc, r;
      conv_out_t res;
      w = (width_reg > MAX_PADDED_WIDTH) ? MAX_PADDED_WIDTH : width_reg;
      if (fs) begin
        col_cnt = '0;
        row_cnt = '0;
      end
      colx = col_cnt;
      rowx = row_cnt;
      if (colx >= MAX_PADDED_WIDTH) colx = 0;
      // shift the column up through the line stores
      for (i = 0; i < N_LINES; i++) fresh[i] = line_rows[i][colx];
      fresh[N_LINES] = px;
      for (i = 0; i + 1 < N_LINES; i++) line_rows[i][colx] = line_rows[i + 1][colx];
      line_rows[N_LINES-1][colx] = px;
      for (i = 0; i < K_SIZE; i++) begin
        for (k = 0; k + 1 < K_SIZE; k++) win[i][k] = win[i][k + 1];
        win[i][K_SIZE-1] = fresh[i];
      end
      last_col = (colx + 1 >= w);
      last_row = (rowx + 1 >= height_reg);
      if (rowx >= N_LINES && colx >= N_LINES) begin
        acc = 0;
        for (i = 0; i < K_SIZE; i++)
          for (k = 0; k < K_SIZE; k++)
            acc += tap((K_SIZE - 1 - i) * K_SIZE + (K_SIZE - 1 - k)) * longint'(win[i][k]);
        r = (acc + 512) >>> COEF_FRAC;
        if (r > longint'(32'sh7FFF_FFFF)) r = longint'(32'sh7FFF_FFFF);
        if (r < longint'(32'sh8000_0000)) r = longint'(32'sh8000_0000);
        res.value = VALUE_W'(r);
        res.row_end = last_col;
        res.frame_end = last_col && last_row;
        expected_values.push_back(res);
      end
      if (last_col) begin
        col_cnt = '0;
        row_cnt = last_row ? '0 : DIM_W'(rowx + 1);
      end else begin
        col_cnt = DIM_W'(colx + 1);
      end
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] value, logic row_end,
                               logic frame_end);
      conv_out_t want;
      if (expected_values.size() == 0) begin
        $error("unexpected result: value %0d", value);
        mismatches++;
        return;
      end
      want = expected_values.pop_front();
      if (value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, value);
        mismatches++;
      end
      if (row_end !== want.row_end) begin
        $error("row_end: expected %0b, got %0b", want.row_end, row_end);
        mismatches++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [PIX_W-1:0]             in_pixel = '0;
  logic                         in_frame_start = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [VALUE_W-1:0]    out_value;
  logic                         out_row_end;
  logic                         out_frame_end;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  bit                           hold_request = 1'b0;
  conv_tracker                  tracker = new();

  image_convolution_2d uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_coef_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return {COEF_PER_WORD{12'h7FF}};
      1: return {COEF_PER_WORD{12'h800}};
      default: return raw[CFG_DATA_W-1:0];
    endcase
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
  endtask

  task automatic load_regs(int unsigned w, int unsigned h,
                           logic [CFG_DATA_W-1:0] words [N_COEF_REGS]);
    cfg_write(CFG_PADDED_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_PADDED_HEIGHT, CFG_DATA_W'(h));
    for (int i = 0; i < N_COEF_REGS; i++)
      cfg_write(CFG_IDX_W'(int'(CFG_COEFF_FIRST) + i), words[i]);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px, logic fs, int gap);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel <= px;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    tracker.note_pixel(px, fs);
  endtask

  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(output int unsigned sent);
    int unsigned w, h, len, n;
    bit eager;
    logic [CFG_DATA_W-1:0] words [N_COEF_REGS];
    case ($urandom_range(0, 9))
      0: w = $urandom_range(0, 2);
      9: w = $urandom_range(13, 40);
      default: w = $urandom_range(3, 12);
    endcase
    case ($urandom_range(0, 9))
      0: h = $urandom_range(0, 2);
      1: h = $urandom_range(0, 1) ? 2047 : $urandom_range(9, 2046);
      default: h = $urandom_range(3, 8);
    endcase
    foreach (words[i]) words[i] = random_coef_word();
    load_regs(w, h, words);
    if (w < K_SIZE || h < K_SIZE || h > 8) len = $urandom_range(20, 80);
    else len = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
    if (len > 300) len = 300;
    eager = ($urandom_range(0, 3) == 0);
    for (n = 0; n < len; n++)
      send_pixel(random_pixel(), n == 0 || $urandom_range(0, 59) == 0,
                 eager ? 0 : $urandom_range(0, 14));
    settle();
    sent = len;
  endtask

  task automatic take_results();
    int taken, pause;
    bit eager;
    taken = 0;
    eager = 1'b0;
    @(negedge clk) out_ready <= 1'b1;
    forever begin
      if (taken % 50 == 0) eager = ($urandom_range(0, 2) == 0);
      pause = eager ? 0 : $urandom_range(0, 14);
      if (hold_request) begin
        hold_request = 1'b0;
        pause = STALL_CYCLES;
      end
      if (pause > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (pause - 1) @(negedge clk);
        @(negedge clk) out_ready <= 1'b1;
      end
      do @(posedge clk); while (!out_valid);
      tracker.check_result(out_value, out_row_end, out_frame_end);
      taken++;
    end
  endtask

  initial begin
    @(posedge rst_n);
    take_results();
  end

  initial begin
    #4_000_000;
    $display("image_convolution_2d regression: fail");
    $finish;
  end

  initial begin
    int unsigned fed, sent, phase;
    logic [CFG_DATA_W-1:0] words [N_COEF_REGS];
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // full-scale window with all-max taps, then all-min taps on a wrapped frame
    cfg_write(CFG_UNUSED_IDX, random_coef_word());
    foreach (words[i]) words[i] = {COEF_PER_WORD{12'h7FF}};
    load_regs(3, 3, words);
    for (int n = 0; n < 9; n++) send_pixel('1, n == 0, 0);
    settle();
    foreach (words[i]) words[i] = {COEF_PER_WORD{12'h800}};
    load_regs(3, 3, words);
    for (int n = 0; n < 9; n++) send_pixel('1, 1'b0, $urandom_range(0, 2));
    settle();

    // half-step rounding, kernel flip, restart inside a frame
    words[0] = {12'h200, 12'h000, 12'h000, 12'h000, 12'hE00};
    words[1] = {12'hABC, 12'h000, 12'h7FF, 12'h800, 12'h001};
    load_regs(3, 3, words);
    send_pixel(16'h0005, 1'b1, 0);
    send_pixel(16'h0007, 1'b0, 0);
    for (int n = 0; n < 9; n++) send_pixel(PIX_W'(2 * n + 1), n == 0, 0);
    settle();

    fed = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      if (phase == 2) begin
        // hold the receiver off while the sender keeps offering back to back
        foreach (words[i]) words[i] = random_coef_word();
        load_regs(10, 8, words);
        for (int n = 0; n < 30; n++) send_pixel(random_pixel(), n == 0, 0);
        hold_request = 1'b1;
        for (int n = 0; n < 90; n++) send_pixel(random_pixel(), 1'b0, 0);
        settle();
        fed += 120;
      end
      random_phase(sent);
      fed += sent;
      phase++;
    end

    if (tracker.mismatches == 0) begin
      $display("image_convolution_2d regression: pass");
    end else begin
      $display("image_convolution_2d regression: fail");
    end
    $finish;
  end

endmodule
